// ----- hw/rtl/thermostat_hysteresis_dwell_defines.svh -----
// Assertion helpers for the thermostat block. Expect clk and rst in scope.
`ifndef THERMOSTAT_HYSTERESIS_DWELL_DEFINES_SVH
`define THERMOSTAT_HYSTERESIS_DWELL_DEFINES_SVH

`define THD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define THD_NEVER(lbl, expr, msg) \
  `THD_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/thd_pkg.sv -----
`default_nettype none
package thd_pkg;

  localparam int TempW   = 12;
  localparam int OffsW   = 9;
  localparam int DwellW  = 16;
  localparam int TickW   = 32;
  localparam int ThrW    = TempW + 1;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic signed [TempW-1:0] TargetReset  = 12'sd370;
  localparam logic signed [OffsW-1:0] StopReset    = 9'sd10;
  localparam logic signed [OffsW-1:0] RestartReset = 9'sd0;
  localparam logic [DwellW-1:0]       DwellReset   = 16'd20;

  localparam logic [CfgIdxW-1:0] CFG_TARGET  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STOP    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESTART = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DWELL   = 2'd3;

  localparam logic [1:0] MODE_UNDEF = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_OFF   = 2'd2;

  localparam logic [1:0] CODE_INIT = 2'd0;
  localparam logic [1:0] CODE_READ = 2'd1;
  localparam logic [1:0] CODE_HIGH = 2'd2;
  localparam logic [1:0] CODE_LOW  = 2'd3;

  typedef enum logic [3:0] {
    PH_INIT = 4'b0001,
    PH_READ = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic signed [TempW-1:0] target_temp;
    logic signed [OffsW-1:0] stop_offset;
    logic signed [OffsW-1:0] restart_offset;
    logic [DwellW-1:0]       dwell_ticks;
  } cfg_t;

  typedef struct packed {
    logic       stop_cells;
    logic       start_cells;
    logic [1:0] cells_state;
    logic [1:0] ctrl_state;
  } res_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_INIT: code = CODE_INIT;
      PH_READ: code = CODE_READ;
      PH_HIGH: code = CODE_HIGH;
      PH_LOW:  code = CODE_LOW;
      default: code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/thd_cfg_regs.sv -----
`default_nettype none
module thd_cfg_regs
  import thd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output      cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp    <= TargetReset;
      cfg.stop_offset    <= StopReset;
      cfg.restart_offset <= RestartReset;
      cfg.dwell_ticks    <= DwellReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET:  cfg.target_temp    <= cfg_data[TempW-1:0];
        CFG_STOP:    cfg.stop_offset    <= cfg_data[OffsW-1:0];
        CFG_RESTART: cfg.restart_offset <= cfg_data[OffsW-1:0];
        CFG_DWELL:   cfg.dwell_ticks    <= cfg_data[DwellW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/thd_ctrl.sv -----
`default_nettype none
`include "thermostat_hysteresis_dwell_defines.svh"
module thd_ctrl
  import thd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire logic signed [TempW-1:0] temperature,
  input  wire logic [TickW-1:0]        now_tick,
  input  wire logic                    reset_cmd,
  input  wire cfg_t                    cfg,
  output      res_t                    res_next
);

  phase_t           phase, phase_next, phase_cur;
  logic [1:0]       cooler_mode, cooler_mode_next;
  logic [TickW-1:0] dwell_start, dwell_start_next;

  logic signed [ThrW-1:0] temp_x, hi_thr, lo_thr;
  logic [TickW-1:0]       elapsed;
  logic                   is_high, is_low, dwell_done;
  logic                   stop, start;

  assign temp_x     = ThrW'(temperature);
  assign hi_thr     = ThrW'(cfg.target_temp) + ThrW'(cfg.stop_offset);
  assign lo_thr     = ThrW'(cfg.target_temp) + ThrW'(cfg.restart_offset);
  assign is_high    = temp_x >= hi_thr;
  assign is_low     = temp_x <= lo_thr;
  assign elapsed    = now_tick - dwell_start;
  assign dwell_done = elapsed >= TickW'(cfg.dwell_ticks);
  assign phase_cur  = reset_cmd ? PH_INIT : phase;

  always_comb begin
    phase_next       = phase_cur;
    cooler_mode_next = cooler_mode;
    dwell_start_next = dwell_start;
    stop             = 1'b0;
    start            = 1'b0;
    case (phase_cur)
      PH_INIT: phase_next = PH_READ;
      PH_READ: begin
        if (is_high) begin
          if (cooler_mode != MODE_OFF) begin
            phase_next       = PH_HIGH;
            dwell_start_next = now_tick;
          end
        end else if (is_low) begin
          if (cooler_mode != MODE_ON) begin
            phase_next       = PH_LOW;
            dwell_start_next = now_tick;
          end
        end
      end
      PH_HIGH: begin
        if (!is_high) begin
          phase_next = PH_READ;
        end else if (dwell_done) begin
          stop             = 1'b1;
          cooler_mode_next = MODE_OFF;
          phase_next       = PH_INIT;
        end
      end
      PH_LOW: begin
        if (!is_low) begin
          phase_next = PH_READ;
        end else if (dwell_done) begin
          start            = 1'b1;
          cooler_mode_next = MODE_ON;
          phase_next       = PH_INIT;
        end
      end
      default: phase_next = PH_READ;
    endcase
  end

  assign res_next.stop_cells  = stop;
  assign res_next.start_cells = start;
  assign res_next.cells_state = cooler_mode_next;
  assign res_next.ctrl_state  = phase_code(phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_INIT;
      cooler_mode <= MODE_UNDEF;
      dwell_start <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      cooler_mode <= cooler_mode_next;
      dwell_start <= dwell_start_next;
    end
  end

  `THD_NEVER(a_one_command, fire && stop && start, "stop and start in one item")
  `THD_ASSERT(a_stop_mode, fire && stop |=> cooler_mode == MODE_OFF, "stop did not set mode off")
  `THD_ASSERT(a_cmd_phase, fire && (stop || start) |-> !reset_cmd && (phase == PH_HIGH || phase == PH_LOW), "command outside check phase")

endmodule
`default_nettype wire

// ----- hw/rtl/thermostat_hysteresis_dwell.sv -----
// Bang-bang thermostat with hysteresis and dwell time.
// Input channel (in_valid/in_stall): one item per periodic call, carrying
// temperature (tenths of a degree, signed), now_tick (free-running, wraps)
// and reset_cmd. Output channel (out_valid/out_stall): exactly one result per
// item with stop_cells, start_cells, cells_state and ctrl_state.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 target,
// 1 stop offset, 2 restart offset, 3 dwell ticks. cfg_ready is always high;
// write only while no item is in flight.
// An accepted item waits in the input register, goes through the controller
// state update and is held in the result register until it is taken.
// Throughput: one item per cycle when the output does not stall, set by the
// single controller state update between the input and result registers.
// A stall on the output holds the result register; the input register keeps
// one item and in_stall rises once both are full, so no item is lost.
// Reset: control state init, cooler mode undefined, dwell start zero,
// registers back to their defaults, both pipeline stages empty.
`default_nettype none
module thermostat_hysteresis_dwell
  import thd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic signed [TempW-1:0] temperature,
  input  wire logic [TickW-1:0]        now_tick,
  input  wire logic                    reset_cmd,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    stop_cells,
  output      logic                    start_cells,
  output      logic [1:0]              cells_state,
  output      logic [1:0]              ctrl_state,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0]      cfg_index,
  input  wire logic [CfgDataW-1:0]     cfg_data
);

  cfg_t cfg;
  res_t res_next, res;

  logic                    in_full;
  logic signed [TempW-1:0] temperature_q;
  logic [TickW-1:0]        now_tick_q;
  logic                    reset_cmd_q;
  logic                    out_room, fire, in_take;

  assign out_room = !out_valid || !out_stall;
  assign fire     = in_full && out_room;
  assign in_stall = in_full && !out_room;
  assign in_take  = in_valid && !in_stall;

  thd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  thd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .temperature (temperature_q),
    .now_tick    (now_tick_q),
    .reset_cmd   (reset_cmd_q),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      temperature_q <= temperature;
      now_tick_q    <= now_tick;
      reset_cmd_q   <= reset_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign stop_cells  = res.stop_cells;
  assign start_cells = res.start_cells;
  assign cells_state = res.cells_state;
  assign ctrl_state  = res.ctrl_state;

endmodule
`default_nettype wire

// ----- tb/thermostat_hysteresis_dwell_test.sv -----
`default_nettype none
module thermostat_hysteresis_dwell_test;
  timeunit 1ns;
  timeprecision 1ps;
  import thd_pkg::*;

  class thermo_scoreboard;
    logic signed [TempW-1:0] target;
    logic signed [OffsW-1:0] stop_off;
    logic signed [OffsW-1:0] restart_off;
    logic [DwellW-1:0]       dwell;
    logic [1:0]              phase;
    logic [1:0]              mode;
    logic [TickW-1:0]        dwell_start;
    res_t                    expected_cmds[$];
    int                      mismatches;

    function new();
      target      = TargetReset;
      stop_off    = StopReset;
      restart_off = RestartReset;
      dwell       = DwellReset;
      phase       = CODE_INIT;
      mode        = MODE_UNDEF;
      dwell_start = '0;
      mismatches  = 0;
    endfunction

    function int high_threshold();
      return int'(target) + int'(stop_off);
    endfunction

    function int low_threshold();
      return int'(target) + int'(restart_off);
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TARGET:  target      = data[TempW-1:0];
        CFG_STOP:    stop_off    = data[OffsW-1:0];
        CFG_RESTART: restart_off = data[OffsW-1:0];
        default:     dwell       = data[DwellW-1:0];
      endcase
    endfunction

    // Advance the controller by one periodic call and queue the command it yields.
    function void log_sample(logic signed [TempW-1:0] temp, logic [TickW-1:0] tick,
                             logic rcmd);
      int               t;
      bit               is_high;
      bit               is_low;
      bit               dwell_done;
      logic [TickW-1:0] elapsed;
      res_t             cmd;
      t          = int'(temp);
      is_high    = t >= high_threshold();
      is_low     = t <= low_threshold();
      elapsed    = tick - dwell_start;
      dwell_done = elapsed >= {{(TickW-DwellW){1'b0}}, dwell};
      cmd        = '0;
      if (rcmd) phase = CODE_INIT;
      case (phase)
        CODE_INIT: phase = CODE_READ;
        CODE_READ: begin
          if (is_high) begin
            if (mode != MODE_OFF) begin
              phase       = CODE_HIGH;
              dwell_start = tick;
            end
          end else if (is_low) begin
            if (mode != MODE_ON) begin
              phase       = CODE_LOW;
              dwell_start = tick;
            end
          end
        end
        CODE_HIGH: begin
          if (!is_high) begin
            phase = CODE_READ;
          end else if (dwell_done) begin
            cmd.stop_cells = 1'b1;
            mode           = MODE_OFF;
            phase          = CODE_INIT;
          end
        end
        default: begin
          if (!is_low) begin
            phase = CODE_READ;
          end else if (dwell_done) begin
            cmd.start_cells = 1'b1;
            mode            = MODE_ON;
            phase           = CODE_INIT;
          end
        end
      endcase
      cmd.cells_state = mode;
      cmd.ctrl_state  = phase;
      expected_cmds.push_back(cmd);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_command(res_t got);
      res_t want;
      if (expected_cmds.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
        return;
      end
      want = expected_cmds.pop_front();
      compare_field("stop_cells", 2'(want.stop_cells), 2'(got.stop_cells));
      compare_field("start_cells", 2'(want.start_cells), 2'(got.start_cells));
      compare_field("cells_state", want.cells_state, got.cells_state);
      compare_field("ctrl_state", want.ctrl_state, got.ctrl_state);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [TempW-1:0] temperature = '0;
  logic [TickW-1:0]        now_tick = '0;
  logic                    reset_cmd = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    stop_cells;
  logic                    start_cells;
  logic [1:0]              cells_state;
  logic [1:0]              ctrl_state;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CfgDataW-1:0]     cfg_data = '0;

  thermo_scoreboard sb = new();
  logic [TickW-1:0] tick_now;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold = 1'b0;

  thermostat_hysteresis_dwell u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .temperature (temperature),
    .now_tick    (now_tick),
    .reset_cmd   (reset_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stop_cells  (stop_cells),
    .start_cells (start_cells),
    .cells_state (cells_state),
    .ctrl_state  (ctrl_state),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_command({stop_cells, start_cells, cells_state, ctrl_state});
    end
  end

  // result side: random stall per item, one long hold when requested
  initial begin
    int n;
    forever begin
      if (rx_hold) begin
        n = $urandom_range(40, 80);
        rx_hold = 1'b0;
      end else begin
        n = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_sample(input int temp, input logic [TickW-1:0] tick, input bit rcmd,
                             input bit last);
    int n;
    in_valid    <= 1'b1;
    temperature <= TempW'(temp);
    now_tick    <= tick;
    reset_cmd   <= rcmd;
    do @(posedge clk); while (in_stall);
    sb.log_sample(TempW'(temp), tick, rcmd);
    n = tx_calm ? 0 : $urandom_range(0, 6);
    if (last || n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  // upper data bits beyond the target, stop and restart register widths carry junk
  task automatic apply_setting(input int tgt, input int stop, input int restart,
                               input int dwell);
    write_reg(CFG_TARGET, {4'($urandom), TempW'(tgt)});
    write_reg(CFG_STOP, {7'($urandom), OffsW'(stop)});
    write_reg(CFG_RESTART, {7'($urandom), OffsW'(restart)});
    write_reg(CFG_DWELL, DwellW'(dwell));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // runs of samples held on one side of a threshold, so dwell timers can expire
  task automatic run_phase(input int count, input bit pause_mid);
    int side;
    int left;
    int t;
    bit rcmd;
    side = 0;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        side = $urandom_range(0, 4);
        left = $urandom_range(1, 10);
      end
      left--;
      case (side)
        0: t = sb.high_threshold() + int'($urandom_range(0, 20));
        1: t = sb.low_threshold() - int'($urandom_range(0, 20));
        2: t = sb.high_threshold() - int'($urandom_range(0, 3));
        3: t = sb.low_threshold() + int'($urandom_range(0, 3));
        default: t = int'($urandom_range(0, 4095)) - 2048;
      endcase
      if (t > 2047) t = 2047;
      if (t < -2048) t = -2048;
      if ($urandom_range(0, 29) == 0) tick_now += $urandom;
      else tick_now += $urandom_range(0, int'(sb.dwell) / 4 + 3);
      rcmd = $urandom_range(0, 24) == 0;
      send_sample(t, tick_now, rcmd, i == count - 1 || (pause_mid && i == count / 2));
      if (pause_mid && i == count / 2) begin
        while (sb.expected_cmds.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: stop at 380 and above, restart at 370 and below, dwell 20
    send_sample(2047, 32'd0, 1'b0, 1'b0);
    send_sample(385, 32'd100, 1'b0, 1'b0);
    send_sample(390, 32'd110, 1'b0, 1'b0);
    send_sample(380, 32'd120, 1'b0, 1'b0);
    send_sample(400, 32'd121, 1'b0, 1'b0);
    send_sample(2047, 32'd130, 1'b0, 1'b0);
    send_sample(370, 32'd140, 1'b0, 1'b0);
    send_sample(375, 32'd150, 1'b0, 1'b0);
    send_sample(-2048, 32'hFFFF_FFF0, 1'b0, 1'b0);
    send_sample(0, 32'd4, 1'b0, 1'b0);
    send_sample(0, 32'd5, 1'b0, 1'b0);
    send_sample(-500, 32'd6, 1'b0, 1'b0);
    send_sample(500, 32'd7, 1'b0, 1'b0);
    send_sample(500, 32'd8, 1'b1, 1'b0);
    send_sample(500, 32'd9, 1'b0, 1'b0);
    send_sample(500, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(-2048, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(1, 32'h8000_0000, 1'b0, 1'b0);
    send_sample(-1, 32'h7FFF_FFFF, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_setting(-1000, -200, 200, 0);
        1: apply_setting(1500, 200, -200, 65535);
        2: apply_setting(-2048, 255, -256, 1);
        3: apply_setting(2047, -256, 255, 3);
        default: apply_setting(int'($urandom_range(0, 2500)) - 1000,
                               int'($urandom_range(0, 400)) - 200,
                               int'($urandom_range(0, 400)) - 200,
                               $urandom_range(0, 40));
      endcase
      tx_calm = p == 4 || p == 5 || p == 8;
      rx_calm = p == 4;
      if (p == 5) rx_hold = 1'b1;
      tick_now = (p == 6) ? 32'hFFFF_FF00 : $urandom;
      run_phase(65, p == 7);
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
